>>> rtl/core/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is checked at every rising clock edge, reset included.
`define PNF_ASSERT(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

// Concurrent assertion that is switched off while the active-low reset is low.
`define PNF_ASSERT_RST(name, clk, rstn, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

`endif

>>> rtl/core/pnf_pkg.sv
// Package with widths, types and helpers of the plane normal pipeline.
`timescale 1ns / 1ps

package pnf_pkg;

    // Point coordinates and edge vectors.
    localparam int COORD_WIDTH  = 32;
    localparam int EDGE_W       = COORD_WIDTH + 1;
    localparam int MAG_W        = COORD_WIDTH + 1;
    localparam int POS_W        = $clog2(MAG_W);

    // The largest normalized magnitude lies in [2^NORM_MSB, 2^(NORM_MSB+1)); the others are smaller.
    localparam int NORM_MSB     = 30;
    localparam int NRM_W        = NORM_MSB + 1;
    localparam int SQ_W         = 2 * NRM_W;
    localparam int SUM_W        = 64;
    localparam int LEN_W        = SUM_W / 2;

    // Square root pipeline.
    localparam int SQRT_PER_STAGE = 2;
    localparam int SQRT_STAGES    = LEN_W / SQRT_PER_STAGE;
    localparam int SQRT_REM_W     = LEN_W + 3;

    // Divider pipeline for the unit components.
    localparam int FRAC_W        = 16;
    localparam int NUM_W         = NRM_W + FRAC_W + 1;
    localparam int Q_W           = 18;
    localparam int DIV_PER_STAGE = 2;
    localparam int DIV_STAGES    = Q_W / DIV_PER_STAGE;
    localparam int DIV_REM_W     = LEN_W + 1;

    // Unit vectors and cross product.
    localparam int UNIT_W       = 18;
    localparam int UNIT_ONE     = 65536;
    localparam int NZ_W         = 17;
    localparam int PROD_W       = 2 * UNIT_W;
    localparam int CROSS_W      = PROD_W + 1;
    localparam int RND_W        = CROSS_W - FRAC_W;

    // Edge length threshold.
    localparam int THR_W        = 16;
    localparam int THR_SQ_W     = 2 * THR_W;
    localparam logic [THR_SQ_W-1:0] THR_SQ_RESET = THR_SQ_W'(1);

    // Stream widths.
    localparam int IN_TDATA_W   = 9 * COORD_WIDTH;
    localparam int OUT_BITS     = 2 * UNIT_W + NZ_W;
    localparam int OUT_TDATA_W  = ((OUT_BITS + 7) / 8) * 8;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [EDGE_W-1:0]      edge_comp_t;

    // Unit edge handed from an edge unit to the cross product stage.
    typedef struct packed {
        logic signed [UNIT_W-1:0] x;
        logic signed [UNIT_W-1:0] y;
        logic signed [UNIT_W-1:0] z;
        logic                     ok;
    } unit_vec_t;

    // Final normal and flag.
    typedef struct packed {
        logic signed [UNIT_W-1:0] x;
        logic signed [UNIT_W-1:0] y;
        logic [NZ_W-1:0]          z;
        logic                     degen;
    } normal_t;

    // Side data that runs beside the square root pipeline.
    typedef struct packed {
        logic [2:0][NRM_W-1:0] ms;
        logic [2:0]            neg;
        logic                  kept;
    } side_t;

    // Position of the highest set bit; zero for a zero word.
    function automatic logic [POS_W-1:0] msb_pos(input logic [MAG_W-1:0] v);
        logic [POS_W-1:0] p;
        p = '0;
        for (int i = 0; i < MAG_W; i++) begin
            if (v[i]) begin
                p = POS_W'(i);
            end
        end
        return p;
    endfunction

endpackage

>>> rtl/core/pnf_isqrt.sv
// Pipelined floor square root, two result bits per stage.
`timescale 1ns / 1ps

module pnf_isqrt
    import pnf_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_valid,
    input  logic [SUM_W-1:0] in_x,
    output logic             out_valid,
    output logic [LEN_W-1:0] out_root
);

    logic [SUM_W-1:0]      x_reg    [SQRT_STAGES];
    logic [SQRT_REM_W-1:0] rem_reg  [SQRT_STAGES];
    logic [LEN_W-1:0]      root_reg [SQRT_STAGES];
    logic                  vld_reg  [SQRT_STAGES];

    for (genvar s = 0; s < SQRT_STAGES; s++) begin : g_stage
        logic [SUM_W-1:0]      x_in;
        logic [SQRT_REM_W-1:0] rem_in;
        logic [LEN_W-1:0]      root_in;
        logic                  vld_in;
        logic [SUM_W-1:0]      x_next;
        logic [SQRT_REM_W-1:0] rem_next;
        logic [LEN_W-1:0]      root_next;

        // Stage inputs come from the port or from the previous stage.
        if (s == 0) begin : g_first
            assign x_in    = in_x;
            assign rem_in  = '0;
            assign root_in = '0;
            assign vld_in  = in_valid;
        end else begin : g_chain
            assign x_in    = x_reg[s-1];
            assign rem_in  = rem_reg[s-1];
            assign root_in = root_reg[s-1];
            assign vld_in  = vld_reg[s-1];
        end

        // Digit-by-digit steps: bring down two bits, try root*4+1.
        always_comb begin
            logic [SQRT_REM_W-1:0] trial;
            logic [SQRT_REM_W-1:0] t;
            x_next    = x_in;
            rem_next  = rem_in;
            root_next = root_in;
            for (int k = 0; k < SQRT_PER_STAGE; k++) begin
                trial  = {rem_next[SQRT_REM_W-3:0], x_next[SUM_W-1:SUM_W-2]};
                x_next = {x_next[SUM_W-3:0], 2'b00};
                t      = SQRT_REM_W'({root_next, 2'b01});
                if (trial >= t) begin
                    rem_next  = trial - t;
                    root_next = {root_next[LEN_W-2:0], 1'b1};
                end else begin
                    rem_next  = trial;
                    root_next = {root_next[LEN_W-2:0], 1'b0};
                end
            end
        end

        // Stage registers.
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[s] <= 1'b0;
            end else if (en) begin
                vld_reg[s] <= vld_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                x_reg[s]    <= x_next;
                rem_reg[s]  <= rem_next;
                root_reg[s] <= root_next;
            end
        end
    end

    assign out_valid = vld_reg[SQRT_STAGES-1];
    assign out_root  = root_reg[SQRT_STAGES-1];

endmodule

>>> rtl/core/pnf_div.sv
// Pipelined restoring divider for one unit component, two quotient bits per stage.
`timescale 1ns / 1ps

module pnf_div
    import pnf_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_valid,
    input  logic [NUM_W-1:0] in_num,
    input  logic [LEN_W-1:0] in_den,
    output logic             out_valid,
    output logic [Q_W-1:0]   out_q
);

    logic [DIV_REM_W-1:0] rem_reg [DIV_STAGES];
    logic [Q_W-1:0]       lo_reg  [DIV_STAGES];
    logic [Q_W-1:0]       q_reg   [DIV_STAGES];
    logic [LEN_W-1:0]     den_reg [DIV_STAGES];
    logic                 vld_reg [DIV_STAGES];

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
        logic [DIV_REM_W-1:0] rem_in;
        logic [Q_W-1:0]       lo_in;
        logic [Q_W-1:0]       q_in;
        logic [LEN_W-1:0]     den_in;
        logic                 vld_in;
        logic [DIV_REM_W-1:0] rem_next;
        logic [Q_W-1:0]       lo_next;
        logic [Q_W-1:0]       q_next;

        // The quotient fits in Q_W bits, so the upper numerator bits start as remainder.
        if (s == 0) begin : g_first
            assign rem_in = DIV_REM_W'(in_num[NUM_W-1:Q_W]);
            assign lo_in  = in_num[Q_W-1:0];
            assign q_in   = '0;
            assign den_in = in_den;
            assign vld_in = in_valid;
        end else begin : g_chain
            assign rem_in = rem_reg[s-1];
            assign lo_in  = lo_reg[s-1];
            assign q_in   = q_reg[s-1];
            assign den_in = den_reg[s-1];
            assign vld_in = vld_reg[s-1];
        end

        // For each quotient bit, shift in one numerator bit and subtract the divisor when it fits.
        always_comb begin
            logic [DIV_REM_W-1:0] trial;
            rem_next = rem_in;
            lo_next  = lo_in;
            q_next   = q_in;
            for (int k = 0; k < DIV_PER_STAGE; k++) begin
                trial   = {rem_next[DIV_REM_W-2:0], lo_next[Q_W-1]};
                lo_next = {lo_next[Q_W-2:0], 1'b0};
                if (trial >= DIV_REM_W'(den_in)) begin
                    rem_next = trial - DIV_REM_W'(den_in);
                    q_next   = {q_next[Q_W-2:0], 1'b1};
                end else begin
                    rem_next = trial;
                    q_next   = {q_next[Q_W-2:0], 1'b0};
                end
            end
        end

        // Stage registers.
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[s] <= 1'b0;
            end else if (en) begin
                vld_reg[s] <= vld_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[s] <= rem_next;
                lo_reg[s]  <= lo_next;
                q_reg[s]   <= q_next;
                den_reg[s] <= den_in;
            end
        end
    end

    assign out_valid = vld_reg[DIV_STAGES-1];
    assign out_q     = q_reg[DIV_STAGES-1];

endmodule

>>> rtl/core/pnf_edge.sv
// Edge unit: length test, normalization, square root and three divisions.
`timescale 1ns / 1ps

module pnf_edge
    import pnf_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic [THR_SQ_W-1:0] thr_sq,
    input  logic                in_valid,
    input  edge_comp_t          in_d [3],
    output logic                out_valid,
    output unit_vec_t           out_u
);

    // Stage 1: magnitudes and signs.
    logic [MAG_W-1:0] m1_reg [3];
    logic [2:0]       neg1_reg;
    logic             v1_reg;

    // Stage 2: squares for the length test and the largest magnitude.
    logic [SQ_W-1:0]  sq2_reg [3];
    logic [MAG_W-1:0] m2_reg  [3];
    logic [MAG_W-1:0] big2_reg;
    logic [MAG_W-1:0] big2_next;
    logic [2:0]       neg2_reg;
    logic             v2_reg;

    // Stage 3: keep decision and leading bit position.
    logic [MAG_W-1:0] m3_reg [3];
    logic [POS_W-1:0] p3_reg;
    logic [2:0]       neg3_reg;
    logic             kept3_reg;
    logic             kept3_next;
    logic             v3_reg;

    // Stage 4: normalized magnitudes.
    logic [NRM_W-1:0] ms4_reg [3];
    logic [2:0]       neg4_reg;
    logic             kept4_reg;
    logic             v4_reg;

    // Stage 5: squares of normalized magnitudes.
    logic [SQ_W-1:0]  sqs5_reg [3];
    side_t            side5_reg;
    logic             v5_reg;

    // Stage 6: sum of squares into the square root.
    logic [SUM_W-1:0] x6_reg;
    side_t            side6_reg;
    logic             v6_reg;

    // Side data delayed over the square root.
    side_t            sd_reg [SQRT_STAGES];
    logic             sqrt_valid;
    logic [LEN_W-1:0] sqrt_len;

    // Stage 7: dividend and divisor.
    logic [NUM_W-1:0] num7_reg [3];
    logic [LEN_W-1:0] den7_reg;
    logic [2:0]       neg7_reg;
    logic             kept7_reg;
    logic             v7_reg;

    // Sign and keep flags delayed over the divider.
    logic [3:0]       nk_reg [DIV_STAGES];
    logic [2:0]       div_valid;
    logic [Q_W-1:0]   div_q [3];

    // Stage 8: clamped signed unit components.
    logic signed [UNIT_W-1:0] u_next [3];
    unit_vec_t        u_reg;
    logic             v8_reg;

    // Valid bits travel with the data.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= sqrt_valid;
            v8_reg <= &div_valid;
        end
    end

    // Largest magnitude of the three.
    always_comb begin
        big2_next = (m1_reg[0] > m1_reg[1]) ? m1_reg[0] : m1_reg[1];
        if (m1_reg[2] > big2_next) begin
            big2_next = m1_reg[2];
        end
    end

    // An edge with a very large component is always kept.
    assign kept3_next = ((big2_reg >> NRM_W) != '0) ||
                        ((SUM_W'(sq2_reg[0]) + SUM_W'(sq2_reg[1]) + SUM_W'(sq2_reg[2]))
                         > SUM_W'(thr_sq));

    // Payload through stages 1 to 7.
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                m1_reg[i]   <= in_d[i][EDGE_W-1] ? MAG_W'(-in_d[i]) : MAG_W'(in_d[i]);
                neg1_reg[i] <= in_d[i][EDGE_W-1];

                sq2_reg[i]  <= SQ_W'(m1_reg[i][NRM_W-1:0]) * SQ_W'(m1_reg[i][NRM_W-1:0]);
                m2_reg[i]   <= m1_reg[i];

                m3_reg[i]   <= m2_reg[i];

                if (p3_reg <= POS_W'(NORM_MSB)) begin
                    ms4_reg[i] <= NRM_W'(m3_reg[i] << (POS_W'(NORM_MSB) - p3_reg));
                end else begin
                    ms4_reg[i] <= NRM_W'(m3_reg[i] >> (p3_reg - POS_W'(NORM_MSB)));
                end

                sqs5_reg[i] <= SQ_W'(ms4_reg[i]) * SQ_W'(ms4_reg[i]);
                side5_reg.ms[i] <= ms4_reg[i];

                num7_reg[i] <= NUM_W'({sd_reg[SQRT_STAGES-1].ms[i], FRAC_W'(0)})
                             + NUM_W'(sqrt_len >> 1);
            end
            big2_reg  <= big2_next;
            neg2_reg  <= neg1_reg;

            p3_reg    <= msb_pos(big2_reg);
            neg3_reg  <= neg2_reg;
            kept3_reg <= kept3_next;

            neg4_reg  <= neg3_reg;
            kept4_reg <= kept3_reg;

            side5_reg.neg  <= neg4_reg;
            side5_reg.kept <= kept4_reg;

            x6_reg    <= SUM_W'(sqs5_reg[0]) + SUM_W'(sqs5_reg[1]) + SUM_W'(sqs5_reg[2]);
            side6_reg <= side5_reg;

            den7_reg  <= sqrt_len;
            neg7_reg  <= sd_reg[SQRT_STAGES-1].neg;
            kept7_reg <= sd_reg[SQRT_STAGES-1].kept;
        end
    end

    // Square root of the normalized squared length.
    pnf_isqrt u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v6_reg),
        .in_x      (x6_reg),
        .out_valid (sqrt_valid),
        .out_root  (sqrt_len)
    );

    // Side data delay line matching the square root latency.
    always_ff @(posedge aclk) begin
        if (en) begin
            sd_reg[0] <= side6_reg;
            for (int i = 1; i < SQRT_STAGES; i++) begin
                sd_reg[i] <= sd_reg[i-1];
            end
        end
    end

    // One divider per component.
    for (genvar c = 0; c < 3; c++) begin : g_div
        pnf_div u_div (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (v7_reg),
            .in_num    (num7_reg[c]),
            .in_den    (den7_reg),
            .out_valid (div_valid[c]),
            .out_q     (div_q[c])
        );
    end

    // Sign and keep flags delay line matching the divider latency.
    always_ff @(posedge aclk) begin
        if (en) begin
            nk_reg[0] <= {neg7_reg, kept7_reg};
            for (int i = 1; i < DIV_STAGES; i++) begin
                nk_reg[i] <= nk_reg[i-1];
            end
        end
    end

    // Clamp to one, apply the sign, zero a dropped edge.
    always_comb begin
        logic [Q_W-1:0] q;
        for (int i = 0; i < 3; i++) begin
            q = (div_q[i] > Q_W'(UNIT_ONE)) ? Q_W'(UNIT_ONE) : div_q[i];
            if (!nk_reg[DIV_STAGES-1][0]) begin
                u_next[i] = '0;
            end else if (nk_reg[DIV_STAGES-1][i+1]) begin
                u_next[i] = -signed'(UNIT_W'(q));
            end else begin
                u_next[i] = signed'(UNIT_W'(q));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            u_reg.x  <= u_next[0];
            u_reg.y  <= u_next[1];
            u_reg.z  <= u_next[2];
            u_reg.ok <= nk_reg[DIV_STAGES-1][0];
        end
    end

    assign out_valid = v8_reg;
    assign out_u     = u_reg;

endmodule

>>> rtl/core/pnf_cross.sv
// Cross product of two unit edges, rounding to Q1.16 and upward flip.
`timescale 1ns / 1ps

module pnf_cross
    import pnf_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      en,
    input  logic      in_valid,
    input  unit_vec_t in_u,
    input  unit_vec_t in_v,
    output logic      out_valid,
    output normal_t   out_n
);

    logic signed [PROD_W-1:0]  p1_reg [6];
    logic                      deg1_reg;
    logic                      v1_reg;
    logic signed [CROSS_W-1:0] c2_reg [3];
    logic                      deg2_reg;
    logic                      v2_reg;
    logic signed [UNIT_W-1:0]  n3_next [3];
    logic signed [UNIT_W-1:0]  n3_reg  [3];
    logic                      deg3_reg;
    logic                      v3_reg;
    normal_t                   n4_reg;
    logic                      v4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // Round each component by magnitude with halves away from zero, saturate.
    always_comb begin
        logic [CROSS_W-1:0] mag;
        logic [RND_W-1:0]   r;
        for (int i = 0; i < 3; i++) begin
            mag = c2_reg[i][CROSS_W-1] ? CROSS_W'(-c2_reg[i]) : CROSS_W'(c2_reg[i]);
            r   = RND_W'((mag + CROSS_W'(UNIT_ONE / 2)) >> FRAC_W);
            if (r > RND_W'(UNIT_ONE)) begin
                r = RND_W'(UNIT_ONE);
            end
            n3_next[i] = c2_reg[i][CROSS_W-1] ? -signed'(UNIT_W'(r)) : signed'(UNIT_W'(r));
        end
    end

    // Products, differences, rounding and flip, one register stage each.
    always_ff @(posedge aclk) begin
        if (en) begin
            p1_reg[0] <= PROD_W'(in_u.y) * PROD_W'(in_v.z);
            p1_reg[1] <= PROD_W'(in_u.z) * PROD_W'(in_v.y);
            p1_reg[2] <= PROD_W'(in_u.z) * PROD_W'(in_v.x);
            p1_reg[3] <= PROD_W'(in_u.x) * PROD_W'(in_v.z);
            p1_reg[4] <= PROD_W'(in_u.x) * PROD_W'(in_v.y);
            p1_reg[5] <= PROD_W'(in_u.y) * PROD_W'(in_v.x);
            deg1_reg  <= !(in_u.ok && in_v.ok);

            c2_reg[0] <= CROSS_W'(p1_reg[0]) - CROSS_W'(p1_reg[1]);
            c2_reg[1] <= CROSS_W'(p1_reg[2]) - CROSS_W'(p1_reg[3]);
            c2_reg[2] <= CROSS_W'(p1_reg[4]) - CROSS_W'(p1_reg[5]);
            deg2_reg  <= deg1_reg;

            for (int i = 0; i < 3; i++) begin
                n3_reg[i] <= n3_next[i];
            end
            deg3_reg <= deg2_reg;

            if (n3_reg[2] < 0) begin
                n4_reg.x <= -n3_reg[0];
                n4_reg.y <= -n3_reg[1];
                n4_reg.z <= NZ_W'(-n3_reg[2]);
            end else begin
                n4_reg.x <= n3_reg[0];
                n4_reg.y <= n3_reg[1];
                n4_reg.z <= NZ_W'(n3_reg[2]);
            end
            n4_reg.degen <= deg3_reg;
        end
    end

    assign out_valid = v4_reg;
    assign out_n     = n4_reg;

endmodule

>>> rtl/core/plane_normal_from_three_points.sv
// Top level of the upward plane normal pipeline.
//
//  Channel  Direction  Handshake             Payload
//  s_       in         s_tvalid / s_tready   s_tdata: a_x a_y a_z b_x b_y b_z c_x c_y c_z
//  m_       out        m_tvalid / m_tready   m_tdata: normal_x normal_y normal_z; m_tuser: degenerate
//  cfg_     in         cfg_valid / cfg_ready cfg_data: min_edge_length
//
// One transaction enters per cycle while the output is not stalled; results pass through the
// 16-stage square root and the 9-stage dividers inside each edge unit.
// Reset clears all valid bits and sets min_edge_length to 1.
// A stall at the output freezes the whole pipeline, and s_tready drops with it.
`timescale 1ns / 1ps

module plane_normal_from_three_points
    import pnf_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z from the lowest bit up
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // normal_x, normal_y, normal_z, zero fill from the lowest bit up
    output logic [OUT_TDATA_W-1:0] m_tdata,
    // degenerate
    output logic                   m_tuser,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [THR_W-1:0]       cfg_data
);

    logic                adv;
    logic [THR_SQ_W-1:0] thr_sq_reg;
    coord_t              pt [9];
    edge_comp_t          e1_reg [3];
    edge_comp_t          e2_reg [3];
    logic                v0_reg;
    logic                u_valid;
    logic                w_valid;
    unit_vec_t           u_vec;
    unit_vec_t           w_vec;
    normal_t             nrm;

    // The pipeline moves whenever the output register is free or being taken.
    assign adv       = !m_tvalid || m_tready;
    assign s_tready  = adv;
    assign cfg_ready = 1'b1;

    // Threshold register, kept as its square for the length test.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_sq_reg <= THR_SQ_RESET;
        end else if (cfg_valid && cfg_ready) begin
            thr_sq_reg <= THR_SQ_W'(cfg_data) * THR_SQ_W'(cfg_data);
        end
    end

    // Unpack the input transaction.
    for (genvar k = 0; k < 9; k++) begin : g_unpack
        assign pt[k] = s_tdata[k*COORD_WIDTH +: COORD_WIDTH];
    end

    // Edge vectors b - a and c - a.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (adv) begin
            v0_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                e1_reg[i] <= EDGE_W'(pt[3+i]) - EDGE_W'(pt[i]);
                e2_reg[i] <= EDGE_W'(pt[6+i]) - EDGE_W'(pt[i]);
            end
        end
    end

    pnf_edge u_edge1 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .thr_sq    (thr_sq_reg),
        .in_valid  (v0_reg),
        .in_d      (e1_reg),
        .out_valid (u_valid),
        .out_u     (u_vec)
    );

    pnf_edge u_edge2 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .thr_sq    (thr_sq_reg),
        .in_valid  (v0_reg),
        .in_d      (e2_reg),
        .out_valid (w_valid),
        .out_u     (w_vec)
    );

    pnf_cross u_cross (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (u_valid && w_valid),
        .in_u      (u_vec),
        .in_v      (w_vec),
        .out_valid (m_tvalid),
        .out_n     (nrm)
    );

    // Pack the result transaction.
    assign m_tdata = OUT_TDATA_W'({nrm.z, nrm.y, nrm.x});
    assign m_tuser = nrm.degen;

endmodule

>>> rtl/core/pnf_checker.sv
// Port-level checker for the plane normal block and its bind.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pnf_checker
    import pnf_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [OUT_TDATA_W-1:0] m_tdata,
    input  logic                   m_tuser
);

    // A held result stays offered.
    `PNF_ASSERT_RST(a_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid, "result dropped while stalled")

    // Reset empties the pipeline.
    `PNF_ASSERT(a_reset, aclk, !aresetn |=> !m_tvalid, "result present after reset")

    // Input is ready exactly when the output stage can move.
    `PNF_ASSERT_RST(a_ready, aclk, aresetn, s_tready == (!m_tvalid || m_tready), "input ready does not follow output stage")

    // A degenerate result carries the zero vector.
    `PNF_ASSERT_RST(a_degen, aclk, aresetn, m_tvalid && m_tuser |-> m_tdata == '0, "degenerate result is not zero")

    // The z component never exceeds one.
    `PNF_ASSERT_RST(a_zmax, aclk, aresetn, m_tvalid |-> m_tdata[52:36] <= 17'd65536, "normal z above one")

endmodule

bind plane_normal_from_three_points pnf_checker u_pnf_checker (.*);

>>> tb/sv/plane_normal_from_three_points_test.sv
// Self-checking testbench of the plane normal pipeline with its own normal predictor.
`timescale 1ns / 1ps

module plane_normal_from_three_points_test;
    import pnf_pkg::*;

    localparam int LATENCY     = 38;
    localparam int CYCLE_LIMIT = 400000;

    // Expected normal and flag of one point triple.
    typedef struct {
        logic signed [17:0] nx;
        logic signed [17:0] ny;
        logic [16:0]        nz;
        logic               degen;
    } normal_exp_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z from the lowest bit up
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    // normal_x, normal_y, normal_z, zero fill from the lowest bit up
    logic [OUT_TDATA_W-1:0] m_tdata;
    // degenerate
    logic                   m_tuser;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [THR_W-1:0]       cfg_data = '0;

    normal_exp_t normal_queue[$];
    logic [15:0] edge_threshold = 16'd1;
    int          mismatch_count = 0;
    int          cycle_count = 0;
    int          hold_off_cycles = 0;
    bit          sink_random = 1'b1;
    int          result_count = 0;

    plane_normal_from_three_points dut (.*);

    always #5 aclk = ~aclk;

    // Cycle counter that ends a hung run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("plane_normal_from_three_points_test NOT OK");
            $finish;
        end
    end

    // Floor square root of a 64-bit word.
    function automatic logic [63:0] floor_sqrt(input logic [63:0] x);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Unit edge in Q1.16; returns whether the edge is long enough to keep.
    function automatic bit unit_edge(input logic signed [63:0] d[3],
                                     output logic signed [63:0] u[3]);
        logic [63:0] m[3];
        logic [63:0] big;
        logic [63:0] len;
        logic [63:0] q;
        logic [63:0] thr;
        bit          kept;
        big = 0;
        for (int i = 0; i < 3; i++) begin
            m[i] = d[i] < 0 ? -d[i] : d[i];
            if (m[i] > big) big = m[i];
        end
        thr = {48'd0, edge_threshold};
        if (big >= 64'd1 << 31) kept = 1'b1;
        else kept = (m[0] * m[0] + m[1] * m[1] + m[2] * m[2]) > thr * thr;
        for (int i = 0; i < 3; i++) u[i] = 0;
        if (!kept || big == 0) return 1'b0;
        while (big < 64'd1 << 30) begin
            big = big << 1;
            for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
        end
        while (big >= 64'd1 << 31) begin
            big = big >> 1;
            for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
        end
        len = floor_sqrt(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
        for (int i = 0; i < 3; i++) begin
            q = ((m[i] << 16) + (len >> 1)) / len;
            if (q > UNIT_ONE) q = UNIT_ONE;
            u[i] = d[i] < 0 ? -$signed(q) : $signed(q);
        end
        return 1'b1;
    endfunction

    // Rounds a Q2.32 product sum to Q1.16 by magnitude and saturates it.
    function automatic logic signed [63:0] round_unit(input logic signed [63:0] p);
        logic [63:0] r;
        r = ((p < 0 ? -p : p) + 64'd32768) >> 16;
        if (r > UNIT_ONE) r = UNIT_ONE;
        return p < 0 ? -$signed(r) : $signed(r);
    endfunction

    function automatic normal_exp_t predict_normal(input logic [IN_TDATA_W-1:0] pts);
        logic signed [63:0] a[3], e1[3], e2[3], u[3], v[3], n[3];
        bit                 ok1, ok2;
        normal_exp_t        res;
        for (int i = 0; i < 3; i++) begin
            a[i]  = $signed(pts[i*32 +: 32]);
            e1[i] = $signed(pts[(3+i)*32 +: 32]) - a[i];
            e2[i] = $signed(pts[(6+i)*32 +: 32]) - a[i];
        end
        ok1 = unit_edge(e1, u);
        ok2 = unit_edge(e2, v);
        n[0] = round_unit(u[1] * v[2] - u[2] * v[1]);
        n[1] = round_unit(u[2] * v[0] - u[0] * v[2]);
        n[2] = round_unit(u[0] * v[1] - u[1] * v[0]);
        if (n[2] < 0) begin
            for (int i = 0; i < 3; i++) n[i] = -n[i];
        end
        res.nx = n[0][17:0];
        res.ny = n[1][17:0];
        res.nz = n[2][16:0];
        res.degen = !(ok1 && ok2);
        return res;
    endfunction

    // Receiver: random stalls, always ready when random stalls are off, or a long hold-off when one is requested.
    always @(negedge aclk) begin
        if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            m_tready <= 1'b0;
        end else if (!sink_random) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(0, 9) < 7) ? 1'b1 : ($urandom_range(0, 19) == 0);
        end
    end

    // Result checker against the oldest expected normal.
    always @(posedge aclk) begin
        normal_exp_t want;
        logic [52:0] got;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[52:0];
            result_count <= result_count + 1;
            if (normal_queue.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) $display("unexpected result %h", got);
            end else begin
                want = normal_queue.pop_front();
                if (got[17:0] !== want.nx || got[35:18] !== want.ny ||
                    got[52:36] !== want.nz || m_tuser !== want.degen ||
                    m_tdata[OUT_TDATA_W-1:53] !== '0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: exp x=%0d y=%0d z=%0d d=%0b got x=%0d y=%0d z=%0d d=%0b",
                                 want.nx, want.ny, want.nz, want.degen,
                                 $signed(got[17:0]), $signed(got[35:18]), got[52:36], m_tuser);
                end
            end
        end
    end

    // Random gap before an item: mostly short, sometimes long.
    function automatic int idle_len();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) n = 0;
        return n;
    endfunction

    // Sends one point triple and records its expected normal. The task returns
    // at the accepting edge; the next falling edge either offers the next item
    // or drops s_tvalid.
    task automatic send_points(input logic [IN_TDATA_W-1:0] pts, input bit gaps = 1);
        int n;
        n = gaps ? idle_len() : 0;
        @(negedge aclk);
        if (n > 0) begin
            s_tvalid <= 1'b0;
            repeat (n) @(negedge aclk);
        end
        s_tdata  <= pts;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        normal_queue.push_back(predict_normal(pts));
    endtask

    function automatic logic [IN_TDATA_W-1:0] pack_points(input logic [31:0] c[9]);
        logic [IN_TDATA_W-1:0] p;
        for (int i = 0; i < 9; i++) p[i*32 +: 32] = c[i];
        return p;
    endfunction

    // Stops offering items and waits until every expected result has come.
    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (normal_queue.size() != 0) @(negedge aclk);
        repeat (LATENCY + 5) @(negedge aclk);
    endtask

    task automatic write_threshold(input logic [15:0] value);
        wait_drained();
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        edge_threshold = value;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Random coordinate: full range, extremes, or small and larger offsets from the base.
    function automatic logic [31:0] rand_coord(input logic [31:0] base);
        case ($urandom_range(0, 9))
            0:       return $urandom;
            1:       return ($urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000);
            2:       return base + $urandom_range(0, 4) - 2;
            3, 4:    return base + $urandom_range(0, 400) - 200;
            default: return base + ($urandom & 32'h00FF_FFFF) - 32'h0080_0000;
        endcase
    endfunction

    task automatic send_random(input bit gaps = 1);
        logic [31:0] c[9];
        c[0] = $urandom; c[1] = $urandom; c[2] = $urandom;
        if ($urandom_range(0, 1)) begin
            c[0] = {{8{c[0][23]}}, c[0][23:0]};
            c[1] = {{8{c[1][23]}}, c[1][23:0]};
            c[2] = {{8{c[2][23]}}, c[2][23:0]};
        end
        for (int i = 3; i < 9; i++) c[i] = rand_coord(c[i % 3]);
        send_points(pack_points(c), gaps);
    endtask

    // Extremes, zero edges, collinear points, axis edges and a flipped normal.
    task automatic test_directed();
        logic [31:0] c[9];
        c = '{0, 0, 0, 0, 0, 0, 0, 0, 0};                      send_points(pack_points(c));
        c = '{0, 0, 0, 1, 0, 0, 0, 1, 0};                      send_points(pack_points(c));
        c = '{0, 0, 0, 2, 0, 0, 0, 2, 0};                      send_points(pack_points(c));
        c = '{0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000, 0};      send_points(pack_points(c));
        c = '{0, 0, 0, 0, 32'h10000, 0, 32'h10000, 0, 0};      send_points(pack_points(c));
        c = '{0, 0, 0, 0, 0, 32'h10000, 32'h10000, 0, 0};      send_points(pack_points(c));
        c = '{0, 0, 0, 5, 5, 5, 10, 10, 10};                   send_points(pack_points(c));
        c = '{0, 0, 0, 32'h10000, 0, 0, 32'hFFFF0000, 0, 0};   send_points(pack_points(c));
        c = '{32'h80000000, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
              32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h80000000};
        send_points(pack_points(c));
        c = '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h80000000,
              32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h80000000};
        send_points(pack_points(c));
        c = '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h80000000, 32'h7FFFFFFF,
              32'h00000001, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000};
        send_points(pack_points(c));
        c = '{1, 2, 3, 1, 2, 3, 100, 200, 300};                send_points(pack_points(c));
        c = '{0, 0, 0, 3, 4, 0, 0, 0, 7};                      send_points(pack_points(c));
        c = '{0, 0, 0, 32'h12345, 32'h6789, 32'hFFFF1234,
              32'hFFFEDCBA, 32'h55555, 32'h3333};
        send_points(pack_points(c));
    endtask

    task automatic test_threshold_settings();
        write_threshold(16'd0);
        repeat (40) send_random();
        write_threshold(16'hFFFF);
        repeat (40) send_random();
        write_threshold(16'd100);
        repeat (40) send_random();
        write_threshold(16'd1);
    endtask

    task automatic test_random_stream();
        repeat (450) send_random();
    endtask

    // Output held off while the sender keeps offering items back to back, then a run with the receiver always ready.
    task automatic test_back_pressure();
        wait_drained();
        hold_off_cycles = 200;
        repeat (80) send_random(1'b0);
        wait_drained();
        sink_random = 1'b0;
        repeat (60) send_random(1'b0);
        sink_random = 1'b1;
    endtask

    initial begin
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_directed();
        test_threshold_settings();
        test_back_pressure();
        test_random_stream();
        wait_drained();
        if (mismatch_count == 0 && normal_queue.size() == 0) begin
            $display("plane_normal_from_three_points_test OK");
        end else begin
            $display("plane_normal_from_three_points_test NOT OK");
        end
        $finish;
    end

endmodule
